FILE: rtl/idb_pkg.sv
// Shared types and codes for the indexed deque buffer.
package idb_pkg;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ       = 3'd4,
    REQ_WRITE      = 3'd5
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } stat_code_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value_out;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
  } out_t;

  // What every cell does with its entry this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2,
    CELL_WRITE_HIT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load;   // capture the targeted entry onto the read-out bus
  } cell_ctl_t;

endpackage

FILE: rtl/indexed_deque_buffer.sv
// Top level of the indexed deque buffer: request decode, occupancy and the cell chain.
//
// Entries are held in logical order in a chain of CAPACITY cells, the front item in
// the first cell. Push front, pop front, push back, write at a position and every
// request that fails complete without a scan: the result strobe (done) rises the cycle after
// start is accepted and busy never rises, so requests may issue every cycle. Pop
// back and read at a position k fetch the entry over the cells' read-out bus, which
// moves one cell toward the front per cycle: busy stays high while the entry moves to the front
// cell, and done rises as busy falls (k = occupancy-1 for pop back). done is high
// for exactly one cycle and the result must be taken then; nothing holds it.
module indexed_deque_buffer #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  idb_pkg::in_t   req,
  output logic           done,
  output idb_pkg::out_t  rsp
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > idb_pkg::POS_W) ? CNT_W : idb_pkg::POS_W;
  localparam int WIDE_W = 64;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [IDX_W-1:0]       cnt;

  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   in_range;
  logic                   start_scan;
  logic                   pop_front;
  idb_pkg::stat_code_t    status_next;
  idb_pkg::cell_ctl_t     ctl_dec;
  idb_pkg::cell_ctl_t     ctl;
  logic [IDX_W-1:0]       target;

  logic [WIDE_W-1:0]      in_wide;
  logic [DATA_WIDTH-1:0]  wr_val;
  logic [WIDE_W-1:0]      front_wide;
  logic [WIDE_W-1:0]      bus_wide;

  logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]  cell_bus  [CAPACITY];

  assign busy     = (state == S_SCAN);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign in_range = (CMP_W'(req.position) < CMP_W'(count));

  assign in_wide    = WIDE_W'(req.value_in);
  assign wr_val     = in_wide[DATA_WIDTH-1:0];
  assign front_wide = WIDE_W'(cell_data[0]);
  assign bus_wide   = WIDE_W'(cell_bus[0]);

  always_comb begin
    ctl_dec.op   = idb_pkg::CELL_HOLD;
    ctl_dec.load = 1'b0;
    target       = '0;
    count_next   = count;
    status_next  = idb_pkg::STAT_OK;
    start_scan   = 1'b0;
    pop_front    = 1'b0;
    unique case (req.req_type)
      idb_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status_next = idb_pkg::STAT_FULL;
        end else begin
          ctl_dec.op = idb_pkg::CELL_TAKE_LEFT;
          count_next = count + CNT_W'(1);
        end
      end
      idb_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_next = idb_pkg::STAT_FULL;
        end else begin
          ctl_dec.op = idb_pkg::CELL_WRITE_HIT;
          target     = IDX_W'(count);
          count_next = count + CNT_W'(1);
        end
      end
      idb_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_next = idb_pkg::STAT_EMPTY;
        end else begin
          ctl_dec.op = idb_pkg::CELL_TAKE_RIGHT;
          pop_front  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      idb_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_next = idb_pkg::STAT_EMPTY;
        end else begin
          ctl_dec.load = 1'b1;
          target       = IDX_W'(count - CNT_W'(1));
          start_scan   = 1'b1;
          count_next   = count - CNT_W'(1);
        end
      end
      idb_pkg::REQ_READ: begin
        if (!in_range) begin
          status_next = idb_pkg::STAT_RANGE;
        end else begin
          ctl_dec.load = 1'b1;
          target       = IDX_W'(req.position);
          start_scan   = 1'b1;
        end
      end
      idb_pkg::REQ_WRITE: begin
        if (!in_range) begin
          status_next = idb_pkg::STAT_RANGE;
        end else begin
          ctl_dec.op = idb_pkg::CELL_WRITE_HIT;
          target     = IDX_W'(req.position);
        end
      end
      default: ;
    endcase
  end

  // Cells only act on an accepted transaction; otherwise entries hold and the bus shifts.
  always_comb begin
    if (accept) begin
      ctl = ctl_dec;
    end else begin
      ctl.op   = idb_pkg::CELL_HOLD;
      ctl.load = 1'b0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_val;
      logic [DATA_WIDTH-1:0] right_val;
      logic [DATA_WIDTH-1:0] bus_val;

      if (i == 0) begin : g_first
        assign left_val = wr_val;
      end else begin : g_mid_left
        assign left_val = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_val = '0;
        assign bus_val   = '0;
      end else begin : g_mid_right
        assign right_val = cell_data[i+1];
        assign bus_val   = cell_bus[i+1];
      end

      idb_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .INDEX      (i)
      ) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .target (target),
        .wr_val (wr_val),
        .left   (left_val),
        .right  (right_val),
        .bus_in (bus_val),
        .data   (cell_data[i]),
        .bus    (cell_bus[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (start_scan) begin
              state <= S_SCAN;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload and scan counter.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cnt               <= target;
          rsp.status        <= status_next;
          rsp.occupancy     <= idb_pkg::OCC_W'(count_next);
          rsp.value_out     <= pop_front ? front_wide[idb_pkg::VAL_W-1:0] : '0;
        end
      end
      S_SCAN: begin
        if (cnt == '0) begin
          rsp.value_out <= bus_wide[idb_pkg::VAL_W-1:0];
        end else begin
          cnt <= cnt - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/idb_cell.sv
// One storage cell of the deque chain: an entry plus one stage of the read-out bus.
module idb_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  idb_pkg::cell_ctl_t    ctl,
  input  logic [IDX_W-1:0]      target,
  input  logic [DATA_WIDTH-1:0] wr_val,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  input  logic [DATA_WIDTH-1:0] bus_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] bus
);

  logic hit;

  assign hit = (target == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      idb_pkg::CELL_TAKE_LEFT:  data <= left;
      idb_pkg::CELL_TAKE_RIGHT: data <= right;
      idb_pkg::CELL_WRITE_HIT: begin
        if (hit) begin
          data <= wr_val;
        end
      end
      default: data <= data;
    endcase
  end

  // Read-out bus moves one cell toward the front each cycle, except when load captures the entry.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bus <= hit ? data : '0;
    end else begin
      bus <= bus_in;
    end
  end

endmodule
